FILE: rtl/ssk_pkg.sv
// ----------------------------------------------------------------------------
// ssk_pkg
// Shared constants and controller/datapath handshake types for the
// key-ordered batch sorter.
// ----------------------------------------------------------------------------
package ssk_pkg;

  localparam int DEF_MAX_ENTRIES = 64;
  localparam int DEF_KEY_BITS    = 32;
  localparam int TAG_BITS        = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // take input records into the store
    logic start;  // begin a selection pass at the current position
    logic scan;   // stream the remaining entries and track the minimum
    logic emit;   // swap and present the pass minimum as a result
  } ssk_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_accept;  // a record carrying batch_end was accepted
    logic scan_done;    // all entries of the pass have been compared
    logic out_free;     // the result register can take a new record
    logic last_pass;    // the current position is the final one
  } ssk_status_t;

endpackage

FILE: rtl/ssk_rec_if.sv
// ----------------------------------------------------------------------------
// ssk_rec_if
// Input record channel: a signed key, a tag and an end-of-batch mark.
// ----------------------------------------------------------------------------
interface ssk_rec_if
  import ssk_pkg::*;
#(
  parameter int KEY_BITS = DEF_KEY_BITS
) ();

  logic                       valid;
  logic                       ready;
  logic signed [KEY_BITS-1:0] key_value;
  logic [TAG_BITS-1:0]        record_tag;
  logic                       batch_end;

  modport source (output valid, key_value, record_tag, batch_end, input ready);
  modport sink   (input valid, key_value, record_tag, batch_end, output ready);

endinterface

FILE: rtl/ssk_res_if.sv
// ----------------------------------------------------------------------------
// ssk_res_if
// Result channel: records in ascending key order with batch flags.
// ----------------------------------------------------------------------------
interface ssk_res_if
  import ssk_pkg::*;
#(
  parameter int KEY_BITS = DEF_KEY_BITS
) ();

  logic                       valid;
  logic                       ready;
  logic signed [KEY_BITS-1:0] sorted_key;
  logic [TAG_BITS-1:0]        sorted_tag;
  logic                       run_end;
  logic                       dropped_any;

  modport source (output valid, sorted_key, sorted_tag, run_end, dropped_any,
                  input ready);
  modport sink   (input valid, sorted_key, sorted_tag, run_end, dropped_any,
                  output ready);

endinterface

FILE: rtl/selection_sort_by_key.sv
// Records load at one per cycle while the sorter is in its load state; no
// new records are taken while a batch is being sorted and emitted.
// Each selection pass is paced by the single read port of the record store
// feeding one compare per cycle.
// Reset: rst clears the fill count, overflow flag and handshakes; the store
// itself is not cleared, since only entries below the fill count are read.
// ----------------------------------------------------------------------------
// selection_sort_by_key
// Collects a batch of keyed records and returns them in ascending key order
// using a selection sort over an on-chip record store.
// ----------------------------------------------------------------------------
module selection_sort_by_key
  import ssk_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int KEY_BITS    = DEF_KEY_BITS
) (
  input  logic       clk,
  input  logic       rst,
  ssk_rec_if.sink    records,
  ssk_res_if.source  sorted
);

  ssk_cmd_t    cmd;
  ssk_status_t status;

  ssk_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  ssk_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .records (records),
    .sorted  (sorted)
  );

endmodule

FILE: rtl/ssk_ctrl.sv
// ----------------------------------------------------------------------------
// ssk_ctrl
// Sequencer for loading, per-position selection passes and result emission.
// ----------------------------------------------------------------------------
module ssk_ctrl
  import ssk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ssk_status_t status,
  output ssk_cmd_t    cmd
);

  typedef enum logic [1:0] {
    LOAD,
    START,
    SCAN,
    EMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD;
    end else begin
      case (state)
        LOAD: begin
          if (status.last_accept) state <= START;
        end
        START: begin
          state <= SCAN;
        end
        SCAN: begin
          if (status.scan_done) state <= EMIT;
        end
        EMIT: begin
          if (status.out_free) state <= status.last_pass ? LOAD : START;
        end
        default: begin
          state <= LOAD;
        end
      endcase
    end
  end

  assign cmd.load  = (state == LOAD);
  assign cmd.start = (state == START);
  assign cmd.scan  = (state == SCAN);
  assign cmd.emit  = (state == EMIT);

endmodule

FILE: rtl/ssk_dpath.sv
// ----------------------------------------------------------------------------
// ssk_dpath
// Record store, scan counters, minimum tracking and the result register.
// ----------------------------------------------------------------------------
module ssk_dpath
  import ssk_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int KEY_BITS    = DEF_KEY_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  ssk_cmd_t       cmd,
  output ssk_status_t    status,
  ssk_rec_if.sink        records,
  ssk_res_if.source      sorted
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int REC_W = KEY_BITS + TAG_BITS;

  // Each store entry holds the key above the tag.
  logic [REC_W-1:0] mem [MAX_ENTRIES];

  logic [CNT_W-1:0] fill;
  logic             overflow;
  logic [IDX_W-1:0] pos;
  logic [CNT_W-1:0] scan_addr;
  logic [REC_W-1:0] rd_data;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_vld;
  logic [REC_W-1:0] cur_rec;
  logic [REC_W-1:0] min_rec;
  logic [IDX_W-1:0] min_idx;
  logic             out_valid;

  logic             in_fire;
  logic             has_room;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [REC_W-1:0] wr_data;
  logic             emit_fire;
  logic             more_to_read;
  logic signed [KEY_BITS-1:0] rd_key;
  logic signed [KEY_BITS-1:0] min_key;

  assign records.ready = cmd.load;
  assign in_fire       = records.valid && cmd.load;
  assign has_room      = (fill < CNT_W'(MAX_ENTRIES));
  assign more_to_read  = (scan_addr < fill);

  assign status.last_accept = in_fire && records.batch_end;
  assign status.scan_done   = !rd_vld && !more_to_read;
  assign status.out_free    = !out_valid || sorted.ready;
  assign status.last_pass   = ((CNT_W'(pos) + CNT_W'(1)) == fill);

  assign emit_fire = cmd.emit && status.out_free;

  assign rd_key  = $signed(rd_data[REC_W-1:TAG_BITS]);
  assign min_key = $signed(min_rec[REC_W-1:TAG_BITS]);

  // Read port: the pass position first, then the entries after it.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pos;
    if (cmd.start) begin
      rd_en = 1'b1;
    end else if (cmd.scan && more_to_read) begin
      rd_en   = 1'b1;
      rd_addr = scan_addr[IDX_W-1:0];
    end
  end

  // Write port: loading, or moving the record at the pass position to where
  // the minimum came from. The position itself is never read again.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill[IDX_W-1:0];
    wr_data = {records.key_value, records.record_tag};
    if (in_fire && has_room) begin
      wr_en = 1'b1;
    end else if (emit_fire) begin
      wr_en   = 1'b1;
      wr_addr = min_idx;
      wr_data = cur_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      overflow  <= 1'b0;
      pos       <= '0;
      scan_addr <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      rd_idx <= rd_addr;

      if (in_fire) begin
        if (has_room) fill <= fill + CNT_W'(1);
        else          overflow <= 1'b1;
        pos <= '0;
      end

      if (cmd.start) begin
        scan_addr <= CNT_W'(pos) + CNT_W'(1);
      end else if (cmd.scan && more_to_read) begin
        scan_addr <= scan_addr + CNT_W'(1);
      end

      // The first data of a pass is the position's own record; later ones
      // replace the minimum only when strictly smaller.
      if (cmd.scan && rd_vld) begin
        if (rd_idx == pos) begin
          cur_rec <= rd_data;
          min_rec <= rd_data;
          min_idx <= pos;
        end else if (min_key > rd_key) begin
          min_rec <= rd_data;
          min_idx <= rd_idx;
        end
      end

      if (emit_fire) begin
        out_valid          <= 1'b1;
        sorted.sorted_key  <= min_key;
        sorted.sorted_tag  <= min_rec[TAG_BITS-1:0];
        sorted.run_end     <= status.last_pass;
        sorted.dropped_any <= overflow;
        if (status.last_pass) begin
          fill     <= '0;
          overflow <= 1'b0;
        end else begin
          pos <= pos + IDX_W'(1);
        end
      end else if (sorted.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sorted.valid = out_valid;

endmodule

FILE: verif/selection_sort_by_key_tb.sv
// ----------------------------------------------------------------------------
// selection_sort_by_key_tb
// Feeds batches of keyed records to the sorter and checks every sorted record,
// its tag and both batch flags against an in-bench selection sort, with bursty
// input, a stalling receiver and batches that fill and overflow the store.
// ----------------------------------------------------------------------------
module selection_sort_by_key_tb;
  import ssk_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RECS   = DEF_MAX_ENTRIES;
  localparam int KB         = DEF_KEY_BITS;
  localparam int QUIET_MAX  = 20000;
  localparam int LONG_HOLD  = 800;
  localparam int DRAIN      = 200;
  localparam int RAND_ITEMS = 196;

  typedef logic signed [KB-1:0] key_t;
  typedef logic [TAG_BITS-1:0]  tag_t;

  localparam key_t KEY_MIN = {1'b1, {(KB-1){1'b0}}};
  localparam key_t KEY_MAX = {1'b0, {(KB-1){1'b1}}};

  typedef struct packed {
    key_t key;
    tag_t tag;
    logic last;
    logic dropped;
  } sorted_rec_t;

  class sort_order_scoreboard;
    key_t        batch_keys[$];
    tag_t        batch_tags[$];
    bit          batch_overflow;
    sorted_rec_t expected_sorted[$];
    int          errors;

    function new();
      batch_overflow = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_sorted.size();
    endfunction

    // Records past the store capacity are lost, even one that ends the batch.
    function void note_record(key_t key, tag_t tag, logic batch_end);
      int   lo;
      key_t k;
      tag_t t;
      sorted_rec_t rec;
      if (batch_keys.size() < MAX_RECS) begin
        batch_keys.push_back(key);
        batch_tags.push_back(tag);
      end else begin
        batch_overflow = 1;
      end
      if (!batch_end) return;
      // Selection sort with a strict compare; ties keep this scheme's order.
      for (int i = 0; i < batch_keys.size(); i++) begin
        lo = i;
        for (int j = i + 1; j < batch_keys.size(); j++)
          if (batch_keys[lo] > batch_keys[j]) lo = j;
        if (lo != i) begin
          k = batch_keys[i];
          t = batch_tags[i];
          batch_keys[i] = batch_keys[lo];
          batch_tags[i] = batch_tags[lo];
          batch_keys[lo] = k;
          batch_tags[lo] = t;
        end
      end
      for (int i = 0; i < batch_keys.size(); i++) begin
        rec.key = batch_keys[i];
        rec.tag = batch_tags[i];
        rec.last = (i == batch_keys.size() - 1);
        rec.dropped = batch_overflow;
        expected_sorted.push_back(rec);
      end
      batch_keys.delete();
      batch_tags.delete();
      batch_overflow = 0;
    endfunction

    function void check_result(key_t key, tag_t tag, logic last, logic dropped);
      sorted_rec_t exp;
      if (expected_sorted.size() == 0) begin
        $display("%0t: unexpected result key %0d tag %h", $time, key, tag);
        errors++;
        return;
      end
      exp = expected_sorted.pop_front();
      if (key !== exp.key) begin
        $display("%0t: sorted_key expected %0d, actual %0d", $time, exp.key, key);
        errors++;
      end
      if (tag !== exp.tag) begin
        $display("%0t: sorted_tag expected %h, actual %h", $time, exp.tag, tag);
        errors++;
      end
      if (last !== exp.last) begin
        $display("%0t: run_end expected %b, actual %b", $time, exp.last, last);
        errors++;
      end
      if (dropped !== exp.dropped) begin
        $display("%0t: dropped_any expected %b, actual %b", $time, exp.dropped, dropped);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  ssk_rec_if #(.KEY_BITS(KB)) rec_ch ();
  ssk_res_if #(.KEY_BITS(KB)) res_ch ();

  selection_sort_by_key #(
    .MAX_ENTRIES(MAX_RECS),
    .KEY_BITS   (KB)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .records(rec_ch),
    .sorted (res_ch)
  );

  sort_order_scoreboard sb = new();
  int burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic key_t pick_key(bit narrow);
    if (narrow) return key_t'($urandom_range(0, 3)) - key_t'(1);
    case ($urandom_range(0, 7))
      0: return KEY_MIN;
      1: return KEY_MAX;
      2: return key_t'($urandom_range(0, 4)) - key_t'(2);
      default: return key_t'($urandom);
    endcase
  endfunction

  // The sender works in bursts; valid drops only between bursts.
  task automatic send_record(key_t key, tag_t tag, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        rec_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    rec_ch.valid      <= 1'b1;
    rec_ch.key_value  <= key;
    rec_ch.record_tag <= tag;
    rec_ch.batch_end  <= last;
    @(posedge clk);
    while (!rec_ch.ready) @(posedge clk);
  endtask

  task automatic send_batch(int count);
    bit narrow;
    narrow = ($urandom_range(0, 2) == 0);
    for (int i = 0; i < count; i++)
      send_record(pick_key(narrow), tag_t'($urandom), i == count - 1);
  endtask

  // Every accepted transaction on either channel goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (rec_ch.valid && rec_ch.ready)
        sb.note_record(rec_ch.key_value, rec_ch.record_tag, rec_ch.batch_end);
      if (res_ch.valid && res_ch.ready)
        sb.check_result(res_ch.sorted_key, res_ch.sorted_tag, res_ch.run_end,
                        res_ch.dropped_any);
    end
  end

  // Receiver: phases of full rate, random stalls and a periodic mask, with one
  // long hold-off once some results have gone by.
  initial begin
    int  phase_len;
    int  style;
    int  seen;
    int  step;
    bit  held;
    seen = 0;
    step = 0;
    held = 0;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (!held && seen >= 40) begin
        held = 1;
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      style = $urandom_range(0, 2);
      phase_len = $urandom_range(10, 80);
      repeat (phase_len) begin
        case (style)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= 1'($urandom_range(0, 1));
          default: res_ch.ready <= (step % 5) != 4;
        endcase
        @(posedge clk);
        step++;
        if (res_ch.valid && res_ch.ready) seen++;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_MAX) begin
      @(posedge clk);
      if ((rec_ch.valid && rec_ch.ready) || (res_ch.valid && res_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int sizes[$];
    int total;
    int pick;
    int tmp;
    rst <= 1'b1;
    rec_ch.valid      <= 1'b0;
    rec_ch.key_value  <= '0;
    rec_ch.record_tag <= '0;
    rec_ch.batch_end  <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extreme keys and tags, with a tie on the most negative key.
    send_record(KEY_MAX, 16'hFFFF, 1'b0);
    send_record(KEY_MIN, 16'h0000, 1'b0);
    send_record(key_t'(0), 16'h0001, 1'b0);
    send_record(key_t'(-1), 16'h0002, 1'b0);
    send_record(KEY_MIN, 16'h0003, 1'b1);
    // A batch of one record.
    send_record(key_t'(7), 16'h1234, 1'b1);
    // Already ascending, then equal keys mixed with a smaller one.
    send_record(key_t'(-3), 16'h0010, 1'b0);
    send_record(key_t'(2), 16'h0011, 1'b0);
    send_record(key_t'(9), 16'h0012, 1'b1);
    send_record(key_t'(5), 16'h0020, 1'b0);
    send_record(key_t'(5), 16'h0021, 1'b0);
    send_record(key_t'(-5), 16'h0022, 1'b0);
    send_record(key_t'(5), 16'h0023, 1'b1);
    // Two equal keys only.
    send_record(KEY_MAX, 16'hAAAA, 1'b0);
    send_record(KEY_MAX, 16'h5555, 1'b1);

    // One batch fills the store exactly; one overflows it, so the record that
    // ends that batch is dropped too. The rest are small batches.
    sizes.push_back(MAX_RECS);
    sizes.push_back(MAX_RECS + 2);
    total = 2 * MAX_RECS + 2;
    while (total < RAND_ITEMS) begin
      sizes.push_back($urandom_range(1, 10));
      total += sizes[$];
    end
    for (int i = sizes.size() - 1; i > 0; i--) begin
      pick = $urandom_range(0, i);
      tmp = sizes[i];
      sizes[i] = sizes[pick];
      sizes[pick] = tmp;
    end
    foreach (sizes[i]) send_batch(sizes[i]);

    rec_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
